>>> rtl/core/spq_pkg.sv
// Shared operation and status codes for the sorted priority queue.
package spq_pkg;

	localparam int OP_W = 2;
	localparam int ST_W = 2;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [ST_W-1:0] status_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_POP    = 2'd1;
	localparam op_t OP_PEEK   = 2'd2;
	localparam op_t OP_CLEAR  = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

endpackage

>>> rtl/core/spq_mem.sv
// Entry store: one write port, one read port, registered read data.
module spq_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, read data registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/spq_seq.sv
// Operation sequencer: circular sorted list in memory, head entry cached in flops.
module spq_seq #(
	parameter int CAPACITY    = 16,
	parameter int KEY_WIDTH   = 16,
	parameter int VALUE_WIDTH = 32,
	parameter int AW          = 4,
	parameter int CW          = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// command side
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  spq_pkg::op_t           cmd_op,
	input  logic [KEY_WIDTH-1:0]   cmd_key,
	input  logic [VALUE_WIDTH-1:0] cmd_value,
	// result side
	input  logic                   res_ready,
	output logic                   res_done,
	output logic [KEY_WIDTH-1:0]   res_key,
	output logic [VALUE_WIDTH-1:0] res_value,
	output spq_pkg::status_t       res_status,
	output logic [CW-1:0]          res_count,
	// memory port
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [KEY_WIDTH+VALUE_WIDTH-1:0] mem_wdata,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr,
	input  logic [KEY_WIDTH+VALUE_WIDTH-1:0] mem_rdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_PUT  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	localparam logic [AW:0]   CAP_A = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [1:0]             state_q;
	logic                   pop_wait_q;
	logic [CW-1:0]          occ_q;
	logic [AW-1:0]          hptr_q;
	logic [AW-1:0]          hole_q;
	logic [KEY_WIDTH-1:0]   hkey_q;
	logic [VALUE_WIDTH-1:0] hval_q;
	logic [KEY_WIDTH-1:0]   ikey_q;
	logic [VALUE_WIDTH-1:0] ival_q;
	logic [KEY_WIDTH-1:0]   rkey_q;
	logic [VALUE_WIDTH-1:0] rval_q;
	spq_pkg::status_t       st_q;
	logic                   use_head_q;

	logic                   accept;
	logic                   full;
	logic                   empty;
	logic [AW-1:0]          occ_a;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic                   shift;
	logic [AW-1:0]          hole_m1;

	// logical slot to physical address, wrapping at CAPACITY
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] l);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, l};
		if (sum >= CAP_A) begin
			sum = sum - CAP_A;
		end
		return sum[AW-1:0];
	endfunction

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign full      = (occ_q == CAP_C);
	assign empty     = (occ_q == '0);
	assign occ_a     = occ_q[AW-1:0];
	assign rd_key    = mem_rdata[KEY_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH];
	assign rd_val    = mem_rdata[VALUE_WIDTH-1:0];
	assign hole_m1   = hole_q - AW'(1);
	// stored entry not smaller than the new key moves up one slot
	assign shift     = ($signed(rd_key) >= $signed(ikey_q));

	// memory access selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = {ikey_q, ival_q};
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd_op == spq_pkg::OP_INSERT && !full) begin
					if (empty) begin
						mem_we    = 1'b1;
						mem_waddr = hptr_q;
						mem_wdata = {cmd_key, cmd_value};
					end else begin
						mem_re    = 1'b1;
						mem_raddr = phys(hptr_q, occ_a - AW'(1));
					end
				end else if (accept && cmd_op == spq_pkg::OP_POP && occ_q > CW'(1)) begin
					mem_re    = 1'b1;
					mem_raddr = phys(hptr_q, AW'(1));
				end
			end
			S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = phys(hptr_q, hole_q);
				if (shift) begin
					mem_wdata = mem_rdata;
					mem_re    = (hole_m1 != '0);
					mem_raddr = phys(hptr_q, hole_m1 - AW'(1));
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = phys(hptr_q, hole_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pop_wait_q <= 1'b0;
			occ_q      <= '0;
			hptr_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						case (cmd_op)
							spq_pkg::OP_INSERT: begin
								if (!full) begin
									if (empty) begin
										occ_q <= CW'(1);
									end else begin
										state_q <= S_INS;
									end
								end
							end
							spq_pkg::OP_POP: begin
								if (!empty) begin
									occ_q      <= occ_q - CW'(1);
									hptr_q     <= phys(hptr_q, AW'(1));
									pop_wait_q <= (occ_q > CW'(1));
								end
							end
							spq_pkg::OP_CLEAR: begin
								occ_q  <= '0;
								hptr_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_INS: begin
					if (!shift) begin
						occ_q   <= occ_q + CW'(1);
						state_q <= S_FIN;
					end else if (hole_m1 == '0) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					occ_q   <= occ_q + CW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					// new head arrives from memory in the cycle after a pop
					pop_wait_q <= 1'b0;
					if (res_ready && !pop_wait_q) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: hole index, pending entry, head cache, result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ikey_q     <= cmd_key;
					ival_q     <= cmd_value;
					hole_q     <= occ_a;
					use_head_q <= 1'b1;
					st_q       <= spq_pkg::ST_OK;
					rkey_q     <= hkey_q;
					rval_q     <= hval_q;
					case (cmd_op)
						spq_pkg::OP_INSERT: begin
							if (full) begin
								st_q <= spq_pkg::ST_FULL;
							end else if (empty) begin
								hkey_q <= cmd_key;
								hval_q <= cmd_value;
							end
						end
						spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
							use_head_q <= 1'b0;
							if (empty) begin
								st_q   <= spq_pkg::ST_EMPTY;
								rkey_q <= '0;
								rval_q <= '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INS: begin
				if (shift) begin
					hole_q <= hole_m1;
				end
			end
			S_PUT: begin
				hkey_q <= ikey_q;
				hval_q <= ival_q;
			end
			S_FIN: begin
				if (pop_wait_q) begin
					hkey_q <= rd_key;
					hval_q <= rd_val;
				end
			end
			default: begin
			end
		endcase
	end

	// result fields
	assign res_done   = (state_q == S_FIN) && res_ready && !pop_wait_q;
	assign res_status = st_q;
	assign res_count  = occ_q;
	assign res_key    = use_head_q ? (empty ? '0 : hkey_q) : rkey_q;
	assign res_value  = use_head_q ? (empty ? '0 : hval_q) : rval_q;

	assert property (@(posedge clk) disable iff (!arst_n) occ_q <= CAP_C)
		else $error("entry count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE && empty) || state_q == S_INS || state_q == S_PUT)
		else $error("memory write outside an insert");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS && shift) |-> !full)
		else $error("shift loop running on a full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_done && st_q == spq_pkg::ST_FULL) |-> full)
		else $error("full status reported on a queue with room");

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: memory, sequencer and result register.
//
//  channel  direction  handshake           payload
//  in       to block   in_valid/in_stall   op, key, value
//  out      from block out_valid/out_stall head_value, head_key, status, entry_count
//
// Peek, clear, empty pop/peek, a rejected insert, an insert into an empty queue
// and a pop that empties the queue go straight to the result state; a pop that
// leaves entries waits there for the new head. An insert into a non-empty queue
// moves entries up one by one, a loop bound by the single memory read port.
// Reset empties the queue at once; memory contents are not cleared.
// A stalled result holds in the output register; the next item is taken meanwhile
// and its result waits in the sequencer until the register frees.
module sorted_priority_queue #(
	parameter int CAPACITY    = 16,
	parameter int KEY_WIDTH   = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  spq_pkg::op_t                    op,
	input  logic [KEY_WIDTH-1:0]            key,
	input  logic [VALUE_WIDTH-1:0]          value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [VALUE_WIDTH-1:0]          head_value,
	output logic [KEY_WIDTH-1:0]            head_key,
	output spq_pkg::status_t                status,
	output logic [$clog2(CAPACITY+1)-1:0]   entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY+1);
	localparam int DW = KEY_WIDTH + VALUE_WIDTH;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [DW-1:0]          mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [DW-1:0]          mem_rdata;

	logic                   res_ready;
	logic                   res_done;
	logic [KEY_WIDTH-1:0]   res_key;
	logic [VALUE_WIDTH-1:0] res_value;
	spq_pkg::status_t       res_status;
	logic [CW-1:0]          res_count;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] head_value_q;
	logic [KEY_WIDTH-1:0]   head_key_q;
	spq_pkg::status_t       status_q;
	logic [CW-1:0]          entry_count_q;

	spq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (DW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	spq_seq #(
		.CAPACITY    (CAPACITY),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.AW          (AW),
		.CW          (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (in_valid),
		.cmd_stall  (in_stall),
		.cmd_op     (op),
		.cmd_key    (key),
		.cmd_value  (value),
		.res_ready  (res_ready),
		.res_done   (res_done),
		.res_key    (res_key),
		.res_value  (res_value),
		.res_status (res_status),
		.res_count  (res_count),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// output register frees when empty or its transfer completes
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			head_value_q  <= res_value;
			head_key_q    <= res_key;
			status_q      <= res_status;
			entry_count_q <= res_count;
		end
	end

	assign out_valid   = out_valid_q;
	assign head_value  = head_value_q;
	assign head_key    = head_key_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule
